@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the checker file (cwdrt_checker.sv).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

@@ sv/cwdrt_pkg.sv @@
// ----------------------------------------------------------------------------
// cwdrt_pkg
// Types and constants for the cell write front end with dirty box tracking.
// ----------------------------------------------------------------------------
package cwdrt_pkg;

  localparam int NUM_CONSOLES = 8;
  localparam int MAX_MAPPABLE = 8;
  // Consoles that can hold dirty state
  localparam int CONS_SLOTS   = (NUM_CONSOLES < MAX_MAPPABLE) ? NUM_CONSOLES : MAX_MAPPABLE;
  localparam int CONS_IDX_W   = (CONS_SLOTS > 1) ? $clog2(CONS_SLOTS) : 1;

  localparam logic [8:0] RESET_WIDTH  = 9'd160;
  localparam logic [8:0] RESET_HEIGHT = 9'd50;
  localparam logic [8:0] DIM_MAX      = 9'd256;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_PRESENT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_MAPPED      = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  console;
    logic [11:0] row;
    logic [11:0] column;
    logic [20:0] codepoint;
    logic [7:0]  foreground;
    logic [7:0]  background;
    logic [15:0] attributes;
  } in_item_t;

  typedef struct packed {
    logic        store_write;
    logic [15:0] cell_address;
    logic [20:0] cell_code;
    logic [7:0]  cell_fore;
    logic [7:0]  cell_back;
    logic [15:0] cell_attr;
    logic        slow_path;
    logic        flush_valid;
    logic [7:0]  rect_x;
    logic [7:0]  rect_y;
    logic [8:0]  rect_w;
    logic [8:0]  rect_h;
  } out_item_t;

endpackage

@@ sv/cell_write_dirty_rect_tracker.sv @@
// ----------------------------------------------------------------------------
// cell_write_dirty_rect_tracker
// Cell write front end for up to eight text consoles with dirty box tracking.
// ----------------------------------------------------------------------------
// Takes one operation per cycle while the output is not stalled (write cell,
// clear console, present console) and returns exactly one result per
// operation. The rate, output stalls aside, is one item per clock: the item
// sits in an input register, the address multiply (8 x 9 bits) and the box
// compare/select run in one stage, and the result register feeds the output.
// A console's box is updated at the same edge the result is registered, so
// the next item sees it. Writes that miss the grid or hit an unmapped console
// flag slow_path. Configuration writes are taken in any cycle (cfg_ready is
// always high) and must only be issued while the block is idle.
module cell_write_dirty_rect_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cwdrt_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cwdrt_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [8:0]           cfg_data
);
  import cwdrt_pkg::*;

  logic [8:0] grid_width;
  logic [8:0] grid_height;
  logic [7:0] mapped_consoles;

  logic       in_vld;
  in_item_t   in_q;
  out_item_t  res;
  logic       adv;

  logic                  dirty_flag   [CONS_SLOTS];
  logic [7:0]            dirty_top    [CONS_SLOTS];
  logic [7:0]            dirty_left   [CONS_SLOTS];
  logic [7:0]            dirty_bottom [CONS_SLOTS];
  logic [7:0]            dirty_right  [CONS_SLOTS];

  logic [CONS_IDX_W-1:0] idx;
  logic                  exists;
  logic                  mapped;
  logic [8:0]            w_eff;
  logic [8:0]            h_eff;
  logic                  in_grid;
  logic [7:0]            row8;
  logic [7:0]            col8;
  logic [16:0]           prod;
  logic                  cur_flag;
  logic [7:0]            cur_top, cur_left, cur_bottom, cur_right;
  logic [8:0]            h_m1, w_m1;

  logic                  box_upd;
  logic                  flag_clr;
  logic [7:0]            top_next, left_next, bottom_next, right_next;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width      <= RESET_WIDTH;
      grid_height     <= RESET_HEIGHT;
      mapped_consoles <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width      <= cfg_data;
        CFG_GRID_HEIGHT: grid_height     <= cfg_data;
        CFG_MAPPED:      mapped_consoles <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: input register -> result register
  assign adv      = in_vld && (!out_valid || out_ready);
  assign in_ready = !in_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) in_vld <= in_valid;
      if (adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_q <= in_item;
    if (adv) out_item <= res;
  end

  // Per-item datapath
  assign idx    = in_q.console[CONS_IDX_W-1:0];
  assign exists = ({1'b0, in_q.console} < 5'(CONS_SLOTS));
  assign mapped = exists && mapped_consoles[in_q.console[2:0]];

  assign w_eff  = (grid_width  > DIM_MAX) ? DIM_MAX : grid_width;
  assign h_eff  = (grid_height > DIM_MAX) ? DIM_MAX : grid_height;
  assign h_m1   = (h_eff == 9'd0) ? 9'd0 : h_eff - 9'd1;
  assign w_m1   = (w_eff == 9'd0) ? 9'd0 : w_eff - 9'd1;

  assign in_grid = (in_q.row < {3'b0, h_eff}) && (in_q.column < {3'b0, w_eff});
  assign row8    = in_q.row[7:0];
  assign col8    = in_q.column[7:0];
  // row < 256 whenever in_grid holds, so the low byte is the whole row
  assign prod    = {9'b0, row8} * {8'b0, w_eff};

  assign cur_flag   = dirty_flag[idx];
  assign cur_top    = dirty_top[idx];
  assign cur_left   = dirty_left[idx];
  assign cur_bottom = dirty_bottom[idx];
  assign cur_right  = dirty_right[idx];

  always_comb begin
    res         = '0;
    box_upd     = 1'b0;
    flag_clr    = 1'b0;
    top_next    = cur_top;
    left_next   = cur_left;
    bottom_next = cur_bottom;
    right_next  = cur_right;
    case (in_q.operation)
      OP_WRITE: begin
        if (mapped && in_grid) begin
          res.store_write  = 1'b1;
          res.cell_address = prod[15:0] + {8'b0, col8};
          res.cell_code    = in_q.codepoint;
          res.cell_fore    = in_q.foreground;
          res.cell_back    = in_q.background;
          res.cell_attr    = in_q.attributes;
          box_upd          = 1'b1;
          if (!cur_flag) begin
            top_next    = row8;
            bottom_next = row8;
            left_next   = col8;
            right_next  = col8;
          end else begin
            if (row8 < cur_top)    top_next    = row8;
            if (row8 > cur_bottom) bottom_next = row8;
            if (col8 < cur_left)   left_next   = col8;
            if (col8 > cur_right)  right_next  = col8;
          end
        end else begin
          res.slow_path = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (mapped) begin
          box_upd     = 1'b1;
          top_next    = '0;
          left_next   = '0;
          bottom_next = h_m1[7:0];
          right_next  = w_m1[7:0];
        end else begin
          res.slow_path = 1'b1;
        end
      end
      OP_PRESENT: begin
        if (exists && cur_flag) begin
          res.flush_valid = 1'b1;
          res.rect_x      = cur_left;
          res.rect_y      = cur_top;
          res.rect_w      = {1'b0, cur_right} - {1'b0, cur_left} + 9'd1;
          res.rect_h      = {1'b0, cur_bottom} - {1'b0, cur_top} + 9'd1;
          flag_clr        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Dirty state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CONS_SLOTS; i++) dirty_flag[i] <= 1'b0;
    end else if (adv) begin
      if (box_upd) dirty_flag[idx] <= 1'b1;
      else if (flag_clr) dirty_flag[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && box_upd) begin
      dirty_top[idx]    <= top_next;
      dirty_left[idx]   <= left_next;
      dirty_bottom[idx] <= bottom_next;
      dirty_right[idx]  <= right_next;
    end
  end

endmodule

@@ sv/cwdrt_checker.sv @@
// ----------------------------------------------------------------------------
// cwdrt_checker
// Port-level checks for the cell write dirty box tracker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cwdrt_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input cwdrt_pkg::out_item_t out_item
);
  import cwdrt_pkg::*;

  logic kind_ok;
  logic rect_clear;
  logic rect_sized;
  logic cell_clear;

  assign kind_ok    = $onehot0({out_item.store_write, out_item.slow_path, out_item.flush_valid});
  assign rect_clear = (out_item.rect_x == 8'd0) && (out_item.rect_y == 8'd0) &&
                      (out_item.rect_w == 9'd0) && (out_item.rect_h == 9'd0);
  assign rect_sized = (out_item.rect_w != 9'd0) && (out_item.rect_h != 9'd0);
  assign cell_clear = (out_item.cell_address == 16'd0) && (out_item.cell_code == 21'd0) &&
                      (out_item.cell_fore == 8'd0) && (out_item.cell_back == 8'd0) &&
                      (out_item.cell_attr == 16'd0);

  // A stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_item))

  // At most one kind of result per transaction
  `ASSERT_IMPL(a_kind_onehot, clk, rst, out_valid, kind_ok)

  // Box fields are zero unless a box is handed out
  `ASSERT_IMPL(a_rect_zero, clk, rst, out_valid && !out_item.flush_valid, rect_clear)

  // A handed out box is never empty
  `ASSERT_IMPL(a_rect_size, clk, rst, out_valid && out_item.flush_valid, rect_sized)

  // Cell fields are zero unless a store is requested
  `ASSERT_IMPL(a_cell_zero, clk, rst, out_valid && !out_item.store_write, cell_clear)

endmodule

bind cell_write_dirty_rect_tracker cwdrt_checker u_cwdrt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cell write front end with dirty box tracking.
// ----------------------------------------------------------------------------
// A directed table covers the grid and console extremes, every operation and
// the corner cases. Random phases then follow, each with fresh grid and
// mapping registers. Every accepted operation runs through a local model of
// the per-console dirty boxes. Each result is checked field by field against
// the oldest outstanding prediction. Both handshakes idle at random. One
// output hold-off backs the block up, and one input pause lets the results
// drain.
module tb_top;
  import cwdrt_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;  // unused operation code
  localparam logic [1:0] CFG_SPARE   = 2'd3;  // register index with no register
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         DRAIN_WAIT  = 16;
  localparam int         HOLD_CYCLES = 80;
  localparam int         PHASES      = 8;
  localparam int         PHASE_OPS   = 125;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [8:0]  reg_data;
    in_item_t    op_item;
    bit          typed;
    out_item_t   typed_res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  // model of the block's registers and per-console boxes
  logic [8:0] grid_w_reg = RESET_WIDTH;
  logic [8:0] grid_h_reg = RESET_HEIGHT;
  logic [7:0] mapped_mask = '0;
  logic       box_dirty [8];
  logic [7:0] box_top [8];
  logic [7:0] box_left [8];
  logic [7:0] box_bottom [8];
  logic [7:0] box_right [8];

  out_item_t  cell_results_due [$];
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         offering = 1'b0;
  logic       quiet = 1'b0;
  int         stall_reqs = 0;
  int         stall_seen = 0;
  int         hold_left = 0;

  cell_write_dirty_rect_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cell_write_dirty_rect_tracker verification failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(logic [8:0] v);
    return (v > 9'd256) ? 256 : int'(v);
  endfunction

  function automatic out_item_t predict_cell_op(in_item_t it);
    out_item_t   r;
    int unsigned w;
    int unsigned h;
    int unsigned c;
    logic [7:0]  r8;
    logic [7:0]  c8;
    r  = '0;
    w  = clamp_dim(grid_w_reg);
    h  = clamp_dim(grid_h_reg);
    c  = it.console;
    r8 = it.row[7:0];
    c8 = it.column[7:0];
    case (it.operation)
      OP_WRITE: begin
        if (c < CONS_SLOTS && mapped_mask[c] && it.row < h && it.column < w) begin
          r.store_write  = 1'b1;
          r.cell_address = 16'(it.row * w + it.column);
          r.cell_code    = it.codepoint;
          r.cell_fore    = it.foreground;
          r.cell_back    = it.background;
          r.cell_attr    = it.attributes;
          if (!box_dirty[c]) begin
            box_top[c]    = r8;
            box_bottom[c] = r8;
            box_left[c]   = c8;
            box_right[c]  = c8;
            box_dirty[c]  = 1'b1;
          end else begin
            if (r8 < box_top[c]) box_top[c] = r8;
            if (r8 > box_bottom[c]) box_bottom[c] = r8;
            if (c8 < box_left[c]) box_left[c] = c8;
            if (c8 > box_right[c]) box_right[c] = c8;
          end
        end else begin
          r.slow_path = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (c < CONS_SLOTS && mapped_mask[c]) begin
          box_top[c]    = '0;
          box_left[c]   = '0;
          box_bottom[c] = 8'((h != 0) ? h - 1 : 0);
          box_right[c]  = 8'((w != 0) ? w - 1 : 0);
          box_dirty[c]  = 1'b1;
        end else begin
          r.slow_path = 1'b1;
        end
      end
      OP_PRESENT: begin
        // a pending box goes out even if the console was unmapped since
        if (c < CONS_SLOTS && box_dirty[c]) begin
          r.flush_valid = 1'b1;
          r.rect_x      = box_left[c];
          r.rect_y      = box_top[c];
          r.rect_w      = 9'(int'(box_right[c]) - int'(box_left[c]) + 1);
          r.rect_h      = 9'(int'(box_bottom[c]) - int'(box_top[c]) + 1);
          box_dirty[c]  = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // output side: random back-pressure, long holds on request, result check
  always @(posedge clk) begin : result_side
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (cell_results_due.size() == 0) begin
        $error("result transaction with no prediction outstanding");
        mismatches++;
      end else begin
        want = cell_results_due.pop_front();
        compare_field("store_write", want.store_write, out_item.store_write);
        compare_field("cell_address", want.cell_address, out_item.cell_address);
        compare_field("cell_code", want.cell_code, out_item.cell_code);
        compare_field("cell_fore", want.cell_fore, out_item.cell_fore);
        compare_field("cell_back", want.cell_back, out_item.cell_back);
        compare_field("cell_attr", want.cell_attr, out_item.cell_attr);
        compare_field("slow_path", want.slow_path, out_item.slow_path);
        compare_field("flush_valid", want.flush_valid, out_item.flush_valid);
        compare_field("rect_x", want.rect_x, out_item.rect_x);
        compare_field("rect_y", want.rect_y, out_item.rect_y);
        compare_field("rect_w", want.rect_w, out_item.rect_w);
        compare_field("rect_h", want.rect_h, out_item.rect_h);
      end
    end
    if (stall_seen != stall_reqs) begin
      stall_seen <= stall_reqs;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 38);
    end
  end

  task automatic stop_offer();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic offer_cell_op(input in_item_t op_item, input bit typed,
                               input out_item_t typed_res);
    out_item_t predicted;
    while (!quiet && $urandom_range(99) < 38) begin
      stop_offer();
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= op_item;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = predict_cell_op(op_item);
    cell_results_due.push_back(typed ? typed_res : predicted);
  endtask

  task automatic wait_idle();
    stop_offer();
    while (cell_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GRID_WIDTH:  grid_w_reg = data;
      CFG_GRID_HEIGHT: grid_h_reg = data;
      CFG_MAPPED:      mapped_mask = data[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic dir_row_t dir_op(logic [1:0] op, logic [3:0] cons, logic [11:0] row,
                                      logic [11:0] col, bit ones, bit typed,
                                      out_item_t res);
    dir_row_t d;
    d.is_cfg             = 1'b0;
    d.reg_idx            = '0;
    d.reg_data           = '0;
    d.op_item            = '0;
    d.op_item.operation  = op;
    d.op_item.console    = cons;
    d.op_item.row        = row;
    d.op_item.column     = col;
    d.op_item.codepoint  = ones ? '1 : '0;
    d.op_item.foreground = ones ? '1 : '0;
    d.op_item.background = ones ? '1 : '0;
    d.op_item.attributes = ones ? '1 : '0;
    d.typed              = typed;
    d.typed_res          = res;
    return d;
  endfunction

  function automatic dir_row_t dir_cfg(logic [1:0] idx, logic [8:0] data);
    dir_row_t d;
    d          = dir_op(OP_SPARE, '0, '0, '0, 1'b0, 1'b0, '0);
    d.is_cfg   = 1'b1;
    d.reg_idx  = idx;
    d.reg_data = data;
    return d;
  endfunction

  initial begin
    dir_row_t    rows [$];
    out_item_t   no_result;
    out_item_t   slow_result;
    out_item_t   full_box;
    in_item_t    op_item;
    int unsigned wd;
    int unsigned ht;
    int          k;
    for (int i = 0; i < 8; i++) begin
      box_dirty[i]  = 1'b0;
      box_top[i]    = '0;
      box_left[i]   = '0;
      box_bottom[i] = '0;
      box_right[i]  = '0;
    end
    no_result             = '0;
    slow_result           = '0;
    slow_result.slow_path = 1'b1;
    // present after a clear on the reset-sized grid
    full_box              = '0;
    full_box.flush_valid  = 1'b1;
    full_box.rect_w       = 9'd160;
    full_box.rect_h       = 9'd50;

    rows.push_back(dir_op(OP_PRESENT, 4'd0, 12'd0, 12'd0, 1'b0, 1'b1, no_result));
    rows.push_back(dir_op(OP_WRITE, 4'd0, 12'd0, 12'd0, 1'b1, 1'b1, slow_result));
    rows.push_back(dir_op(OP_CLEAR, 4'd2, 12'd0, 12'd0, 1'b0, 1'b1, slow_result));
    rows.push_back(dir_cfg(CFG_MAPPED, 9'h1FF));
    rows.push_back(dir_op(OP_WRITE, 4'd0, 12'd0, 12'd0, 1'b1, 1'b0, no_result));
    rows.push_back(dir_op(OP_WRITE, 4'd0, 12'd49, 12'd159, 1'b0, 1'b0, no_result));
    rows.push_back(dir_op(OP_WRITE, 4'd0, 12'd50, 12'd0, 1'b1, 1'b1, slow_result));
    rows.push_back(dir_op(OP_WRITE, 4'd0, 12'd0, 12'd160, 1'b1, 1'b1, slow_result));
    rows.push_back(dir_op(OP_WRITE, 4'd15, 12'd0, 12'd0, 1'b1, 1'b1, slow_result));
    rows.push_back(dir_op(OP_WRITE, 4'd8, 12'hFFF, 12'hFFF, 1'b1, 1'b1, slow_result));
    rows.push_back(dir_op(OP_PRESENT, 4'd0, 12'd0, 12'd0, 1'b0, 1'b0, no_result));
    rows.push_back(dir_op(OP_PRESENT, 4'd0, 12'd0, 12'd0, 1'b0, 1'b1, no_result));
    rows.push_back(dir_op(OP_CLEAR, 4'd7, 12'd0, 12'd0, 1'b0, 1'b1, no_result));
    rows.push_back(dir_op(OP_CLEAR, 4'd12, 12'd0, 12'd0, 1'b0, 1'b1, slow_result));
    rows.push_back(dir_op(OP_PRESENT, 4'd7, 12'd0, 12'd0, 1'b0, 1'b1, full_box));
    rows.push_back(dir_op(OP_SPARE, 4'd3, 12'hFFF, 12'hFFF, 1'b1, 1'b1, no_result));
    rows.push_back(dir_op(OP_PRESENT, 4'd15, 12'd0, 12'd0, 1'b1, 1'b1, no_result));
    // box survives unmapping and is still handed out
    rows.push_back(dir_op(OP_WRITE, 4'd5, 12'd10, 12'd20, 1'b0, 1'b0, no_result));
    rows.push_back(dir_cfg(CFG_MAPPED, 9'h000));
    rows.push_back(dir_cfg(CFG_SPARE, 9'h1FF));
    rows.push_back(dir_op(OP_PRESENT, 4'd5, 12'd0, 12'd0, 1'b0, 1'b0, no_result));
    // zero width, oversized height
    rows.push_back(dir_cfg(CFG_MAPPED, 9'h0FF));
    rows.push_back(dir_cfg(CFG_GRID_WIDTH, 9'd0));
    rows.push_back(dir_cfg(CFG_GRID_HEIGHT, 9'h1FF));
    rows.push_back(dir_op(OP_WRITE, 4'd1, 12'd0, 12'd0, 1'b1, 1'b1, slow_result));
    rows.push_back(dir_op(OP_CLEAR, 4'd1, 12'd0, 12'd0, 1'b0, 1'b1, no_result));
    rows.push_back(dir_op(OP_PRESENT, 4'd1, 12'd0, 12'd0, 1'b0, 1'b0, no_result));
    rows.push_back(dir_cfg(CFG_GRID_WIDTH, 9'd256));
    rows.push_back(dir_cfg(CFG_GRID_HEIGHT, 9'd256));
    rows.push_back(dir_op(OP_WRITE, 4'd2, 12'd255, 12'd255, 1'b1, 1'b0, no_result));
    rows.push_back(dir_op(OP_WRITE, 4'd2, 12'd0, 12'd0, 1'b0, 1'b0, no_result));
    rows.push_back(dir_op(OP_WRITE, 4'd2, 12'd256, 12'd0, 1'b1, 1'b1, slow_result));
    rows.push_back(dir_op(OP_PRESENT, 4'd2, 12'd0, 12'd0, 1'b0, 1'b0, no_result));
    rows.push_back(dir_cfg(CFG_GRID_WIDTH, 9'd1));
    rows.push_back(dir_cfg(CFG_GRID_HEIGHT, 9'd1));
    rows.push_back(dir_op(OP_WRITE, 4'd3, 12'd0, 12'd0, 1'b1, 1'b0, no_result));
    rows.push_back(dir_op(OP_PRESENT, 4'd3, 12'd0, 12'd0, 1'b0, 1'b0, no_result));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_idle();
        write_register(rows[i].reg_idx, rows[i].reg_data);
      end else begin
        offer_cell_op(rows[i].op_item, rows[i].typed, rows[i].typed_res);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      k = $urandom_range(9);
      write_register(CFG_GRID_WIDTH, (k == 0) ? 9'd0 : (k == 1) ? 9'd1 : (k == 2) ? 9'd256 :
                     (k == 3) ? 9'($urandom_range(257, 511)) : 9'($urandom_range(1, 256)));
      k = $urandom_range(9);
      write_register(CFG_GRID_HEIGHT, (k == 0) ? 9'd0 : (k == 1) ? 9'd1 : (k == 2) ? 9'd256 :
                     (k == 3) ? 9'($urandom_range(257, 511)) : 9'($urandom_range(1, 256)));
      write_register(CFG_MAPPED, ($urandom_range(3) == 0) ? 9'($urandom) : 9'h0FF);
      quiet <= (phase == 5);
      wd = clamp_dim(grid_w_reg);
      ht = clamp_dim(grid_h_reg);
      for (int n = 0; n < PHASE_OPS; n++) begin
        if (phase == 3 && n == 30) stall_reqs <= stall_reqs + 1;
        if (phase == 4 && n == 60) wait_idle();
        op_item = '0;
        k = $urandom_range(99);
        if (k < 60) op_item.operation = OP_WRITE;
        else if (k < 66) op_item.operation = OP_CLEAR;
        else if (k < 94) op_item.operation = OP_PRESENT;
        else op_item.operation = OP_SPARE;
        op_item.console = ($urandom_range(99) < 88) ? 4'($urandom_range(7))
                                                    : 4'($urandom_range(15));
        op_item.row = (ht != 0 && $urandom_range(99) < 85) ? 12'($urandom_range(ht - 1))
                                                            : 12'($urandom_range(4095));
        op_item.column = (wd != 0 && $urandom_range(99) < 85) ? 12'($urandom_range(wd - 1))
                                                               : 12'($urandom_range(4095));
        op_item.codepoint  = 21'($urandom);
        op_item.foreground = 8'($urandom);
        op_item.background = 8'($urandom);
        op_item.attributes = 16'($urandom);
        offer_cell_op(op_item, 1'b0, no_result);
      end
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("cell_write_dirty_rect_tracker verification clean");
    end else begin
      $display("cell_write_dirty_rect_tracker verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/cwdrt_pkg.sv
sv/cell_write_dirty_rect_tracker.sv
sv/cwdrt_checker.sv
sim/tb_top.sv
